// ===== design/mtcs_pkg.sv =====
// Shared types, register codes, constants and table functions of the multi-tone
// cosine synthesiser. No dependencies; every other file of the block refers to
// this package by scoped names.
package mtcs_pkg;

   localparam int COS_BITS      = 15;   // magnitude bits of a Q1.15 table entry
   localparam int SAMPLE_BITS   = 16;
   localparam int COUNT_BITS    = 3;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int NUM_STEP_REGS = 4;    // step registers present in the register map
   localparam int PROD_BITS     = 31;   // amplitude times cosine, magnitude below 2^30
   localparam int ACC_BITS      = 17;   // running sum with one guard bit
   localparam int WIDE_BITS     = 32;   // running sum scaled by 2^15 plus one product

   localparam logic [COUNT_BITS-1:0] TONE_COUNT_RESET   = 3'd1;
   localparam logic [31:0]           SAMPLE_TOTAL_RESET = 32'd48000;

   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint unsigned ONE_Q30    = 64'd1073741824;

   typedef enum logic [2:0] {
      REG_TONE_COUNT   = 3'd0,
      REG_SAMPLE_TOTAL = 3'd1,
      REG_STEP_A       = 3'd2,
      REG_STEP_B       = 3'd3,
      REG_STEP_C       = 3'd4,
      REG_STEP_D       = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] tone_count;
      logic [31:0]           sample_total;
   } cfg_type;

   // Quarter-wave cosine entry k of a table addressed by index_bits phase bits.
   // Ten-term Taylor series in Q2.30, rounded half up to Q1.15 and capped at 32767.
   // Only evaluated at elaboration.
   function automatic logic [COS_BITS-1:0] taylor_cos_q15(input int unsigned k,
                                                         input int unsigned index_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x    = (TWO_PI_Q30 * 64'(k)) >> index_bits;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      acc  = longint'(ONE_Q30);
      term = ((term * x2) >> 30) / 64'd2;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd12;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd30;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd56;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd90;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd132;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd182;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd240;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd306;
      acc  = acc - longint'(term);
      if (acc < 0) begin
         acc = 0;
      end
      acc = (acc + 16384) / 32768;
      if (acc > 32767) begin
         acc = 32767;
      end
      return COS_BITS'(acc);
   endfunction

   // Per-tone amplitude, 32767 divided by the tone count, as a small table.
   function automatic logic [COS_BITS-1:0] amp_for(input logic [COUNT_BITS-1:0] n);
      logic [COS_BITS-1:0] amp;
      case (n)
         3'd1:    amp = 15'd32767;
         3'd2:    amp = 15'd16383;
         3'd3:    amp = 15'd10922;
         3'd4:    amp = 15'd8191;
         3'd5:    amp = 15'd6553;
         3'd6:    amp = 15'd5461;
         3'd7:    amp = 15'd4681;
         default: amp = 15'd0;
      endcase
      return amp;
   endfunction

endpackage

// ===== design/mtcs_csr.sv =====
// Configuration register file of the multi-tone cosine synthesiser, with an
// APB-style access port. Depends on mtcs_pkg.
module mtcs_csr #(
   parameter int MAX_TONES = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mtcs_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [mtcs_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [mtcs_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output mtcs_pkg::cfg_type                    cfg,
   output logic [31:0]                          phase_step [MAX_TONES]
);

   logic                                 wr_en;
   logic [2:0]                           reg_sel;
   mtcs_pkg::reg_index_type              reg_code;
   logic [mtcs_pkg::COUNT_BITS-1:0]      tone_count_ff, tone_count_in;
   logic [31:0]                          sample_total_ff, sample_total_in;
   logic [31:0]                          step_view [mtcs_pkg::NUM_STEP_REGS];

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];
   assign reg_code   = mtcs_pkg::reg_index_type'(reg_sel);

   always_comb begin
      tone_count_in   = tone_count_ff;
      sample_total_in = sample_total_ff;
      if (wr_en && (reg_code == mtcs_pkg::REG_TONE_COUNT)) begin
         tone_count_in = csr_pwdata[mtcs_pkg::COUNT_BITS-1:0];
      end
      if (wr_en && (reg_code == mtcs_pkg::REG_SAMPLE_TOTAL)) begin
         sample_total_in = csr_pwdata[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_count_ff   <= mtcs_pkg::TONE_COUNT_RESET;
         sample_total_ff <= mtcs_pkg::SAMPLE_TOTAL_RESET;
      end else begin
         tone_count_ff   <= tone_count_in;
         sample_total_ff <= sample_total_in;
      end
   end

   assign cfg.tone_count   = tone_count_ff;
   assign cfg.sample_total = sample_total_ff;

   // Tones beyond the register map have no step register and stand still.
   for (genvar t = 0; t < MAX_TONES; t++) begin : g_step
      if (t < mtcs_pkg::NUM_STEP_REGS) begin : g_reg
         logic [31:0] step_ff, step_in;
         logic        step_we;
         assign step_we = wr_en && (reg_sel == (3'(mtcs_pkg::REG_STEP_A) + 3'(t)));
         always_comb begin
            step_in = step_ff;
            if (step_we) begin
               step_in = csr_pwdata[31:0];
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               step_ff <= '0;
            end else begin
               step_ff <= step_in;
            end
         end
         assign phase_step[t] = step_ff;
      end else begin : g_none
         assign phase_step[t] = '0;
      end
   end

   for (genvar t = 0; t < mtcs_pkg::NUM_STEP_REGS; t++) begin : g_view
      if (t < MAX_TONES) begin : g_live
         assign step_view[t] = phase_step[t];
      end else begin : g_zero
         assign step_view[t] = '0;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_code)
         mtcs_pkg::REG_TONE_COUNT:   csr_prdata = 32'(tone_count_ff);
         mtcs_pkg::REG_SAMPLE_TOTAL: csr_prdata = sample_total_ff;
         mtcs_pkg::REG_STEP_A:       csr_prdata = step_view[0];
         mtcs_pkg::REG_STEP_B:       csr_prdata = step_view[1];
         mtcs_pkg::REG_STEP_C:       csr_prdata = step_view[2];
         mtcs_pkg::REG_STEP_D:       csr_prdata = step_view[3];
         default:                    csr_prdata = '0;
      endcase
   end

endmodule

// ===== design/mtcs_cos_lookup.sv =====
// Quarter-wave cosine lookup for one tone: folds the quadrant of the phase onto
// a constant Q1.15 table built at elaboration. Depends on mtcs_pkg.
module mtcs_cos_lookup #(
   parameter int TABLE_INDEX_BITS = 10
) (
   input  logic [TABLE_INDEX_BITS-1:0]       phase_top,
   output logic signed [mtcs_pkg::SAMPLE_BITS-1:0] cos_value
);

   localparam int QUARTER_BITS = TABLE_INDEX_BITS - 2;
   localparam int QUARTER      = 1 << QUARTER_BITS;
   localparam logic [mtcs_pkg::COS_BITS-1:0] ROM_END =
      mtcs_pkg::taylor_cos_q15(QUARTER, TABLE_INDEX_BITS);

   logic [mtcs_pkg::COS_BITS-1:0] rom [QUARTER];
   logic [1:0]                    quad;
   logic [QUARTER_BITS-1:0]       offset;
   logic [QUARTER_BITS-1:0]       addr;
   logic [mtcs_pkg::COS_BITS-1:0] mag;
   logic                          negate;

   for (genvar k = 0; k < QUARTER; k++) begin : g_rom
      assign rom[k] = mtcs_pkg::taylor_cos_q15(k, TABLE_INDEX_BITS);
   end

   assign quad   = phase_top[TABLE_INDEX_BITS-1:TABLE_INDEX_BITS-2];
   assign offset = phase_top[QUARTER_BITS-1:0];
   // Odd quadrants read the mirrored entry; at offset zero that is the entry
   // just past the stored range, which is held as a constant.
   assign addr   = quad[0] ? (~offset + {{(QUARTER_BITS-1){1'b0}}, 1'b1}) : offset;
   assign mag    = (quad[0] && (offset == '0)) ? ROM_END : rom[addr];
   assign negate = quad[1] ^ quad[0];

   always_comb begin
      if (negate) begin
         cos_value = -$signed({1'b0, mag});
      end else begin
         cos_value = $signed({1'b0, mag});
      end
   end

endmodule

// ===== design/mtcs_tone_acc.sv =====
// Phase accumulators of all tones and the burst sample counter, advanced once
// per accepted request. Depends on mtcs_pkg.
module mtcs_tone_acc #(
   parameter int MAX_TONES        = 4,
   parameter int TABLE_INDEX_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          restart,
   input  mtcs_pkg::cfg_type             cfg,
   input  logic [31:0]                   phase_step [MAX_TONES],
   output logic [TABLE_INDEX_BITS-1:0]   phase_top [MAX_TONES],
   output logic                          last_sample
);

   logic [31:0] phase_ff [MAX_TONES];
   logic [31:0] phase_in [MAX_TONES];
   logic [31:0] phase_cur [MAX_TONES];
   logic [31:0] index_ff, index_in, index_cur;

   // A restart acts before this sample is formed.
   assign index_cur   = restart ? '0 : index_ff;
   assign last_sample = (index_cur == (cfg.sample_total - 32'd1));
   assign index_in    = last_sample ? '0 : (index_cur + 32'd1);

   for (genvar t = 0; t < MAX_TONES; t++) begin : g_tone
      assign phase_cur[t] = restart ? '0 : phase_ff[t];
      assign phase_in[t]  = last_sample ? '0 : (phase_cur[t] + phase_step[t]);
      assign phase_top[t] = phase_cur[t][31 -: TABLE_INDEX_BITS];

      always_ff @(posedge clock) begin
         if (reset) begin
            phase_ff[t] <= '0;
         end else if (accept) begin
            phase_ff[t] <= phase_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else if (accept) begin
         index_ff <= index_in;
      end
   end

endmodule

// ===== design/mtcs_mixer.sv =====
// Three-stage mixing pipeline: cosine register, amplitude products, then the
// truncating sum with saturation into the result register. Depends on mtcs_pkg.
module mtcs_mixer #(
   parameter int MAX_TONES = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [mtcs_pkg::SAMPLE_BITS-1:0] cos_value [MAX_TONES],
   input  logic                                    in_last,
   input  logic [mtcs_pkg::COUNT_BITS-1:0]         tone_count,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [mtcs_pkg::SAMPLE_BITS-1:0]        out_sample,
   output logic                                    out_last
);

   logic [mtcs_pkg::COUNT_BITS-1:0]               n_eff;
   logic [mtcs_pkg::COS_BITS-1:0]                 amp;

   logic                                          ready1, ready2, ready3;
   logic                                          valid1_ff, valid1_in;
   logic                                          valid2_ff, valid2_in;
   logic                                          valid3_ff, valid3_in;
   logic                                          last1_ff, last2_ff, last3_ff;
   logic signed [mtcs_pkg::SAMPLE_BITS-1:0]       cos_ff [MAX_TONES];
   logic signed [mtcs_pkg::PROD_BITS-1:0]         prod_ff [MAX_TONES];
   logic signed [mtcs_pkg::PROD_BITS-1:0]         prod_in [MAX_TONES];
   logic [mtcs_pkg::SAMPLE_BITS-1:0]              sample_ff, sample_in;

   assign n_eff = ({1'b0, tone_count} > 4'(MAX_TONES)) ?
                  mtcs_pkg::COUNT_BITS'(MAX_TONES) : tone_count;
   assign amp   = mtcs_pkg::amp_for(n_eff);

   // Each stage takes new data when it is empty or its successor moves on.
   assign ready3   = !valid3_ff || out_ready;
   assign ready2   = !valid2_ff || ready3;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   assign valid1_in = ready1 ? in_valid  : valid1_ff;
   assign valid2_in = ready2 ? valid1_ff : valid2_ff;
   assign valid3_in = ready3 ? valid2_ff : valid3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   for (genvar t = 0; t < MAX_TONES; t++) begin : g_lane
      assign prod_in[t] = mtcs_pkg::PROD_BITS'($signed({1'b0, amp}) * cos_ff[t]);

      always_ff @(posedge clock) begin
         if (ready1) begin
            cos_ff[t] <= cos_value[t];
         end
         if (ready2) begin
            prod_ff[t] <= prod_in[t];
         end
      end
   end

   // Truncation toward zero after every tone: bias negative totals before the
   // arithmetic shift.
   always_comb begin
      logic signed [mtcs_pkg::ACC_BITS-1:0]  acc;
      logic signed [mtcs_pkg::WIDE_BITS-1:0] total;
      acc   = '0;
      total = '0;
      for (int t = 0; t < MAX_TONES; t++) begin
         if (4'(t) < {1'b0, n_eff}) begin
            total = $signed({acc, 15'd0}) + mtcs_pkg::WIDE_BITS'(prod_ff[t]);
            if (total < 0) begin
               total = total + 32'sd32767;
            end
            acc = total[mtcs_pkg::WIDE_BITS-1:15];
         end
      end
      if (acc > 17'sd32767) begin
         sample_in = 16'h7FFF;
      end else if (acc < -17'sd32768) begin
         sample_in = 16'h8000;
      end else begin
         sample_in = acc[mtcs_pkg::SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         last1_ff <= in_last;
      end
      if (ready2) begin
         last2_ff <= last1_ff;
      end
      if (ready3) begin
         last3_ff  <= last2_ff;
         sample_ff <= sample_in;
      end
   end

   assign out_valid  = valid3_ff;
   assign out_sample = sample_ff;
   assign out_last   = last3_ff;

endmodule

// ===== design/multi_tone_cosine_synth.sv =====
// Top level of the multi-tone cosine synthesiser: register file, phase
// accumulators, per-tone cosine lookup and the mixing pipeline.
// Depends on mtcs_pkg, mtcs_csr, mtcs_tone_acc, mtcs_cos_lookup and mtcs_mixer.
//
//   Channel   Direction   Carries
//   req_*     in          one sample tick per request, restart flag
//   rsp_*     out         one signed 16-bit sample per request, tlast on burst end
//   csr_*     in/out      tone count, burst length, four phase steps
//
// One request is taken every cycle while the pipeline is not stalled; its sample
// passes the cosine register and product register into the result (sum) register.
// The phase accumulators and sample counter update in the cycle a request is
// taken, so the 32-bit phase add sets the loop timing. A stalled result holds
// the pipeline stage by stage; requests keep flowing until all three stages are
// full. Reset restores register defaults, zeroes phases and the counter and
// empties the pipeline.
module multi_tone_cosine_synth #(
   parameter int MAX_TONES        = 4,
   parameter int TABLE_INDEX_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [0] restart, [7:1] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mtcs_pkg::SAMPLE_BITS-1:0]      rsp_tdata,   // [15:0] sample
   output logic                                  rsp_tlast,   // last_sample
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mtcs_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mtcs_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [mtcs_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   mtcs_pkg::cfg_type                       cfg;
   logic [31:0]                             phase_step [MAX_TONES];
   logic [TABLE_INDEX_BITS-1:0]             phase_top [MAX_TONES];
   logic signed [mtcs_pkg::SAMPLE_BITS-1:0] cos_value [MAX_TONES];
   logic                                    accept;
   logic                                    last_sample;

   assign accept = req_tvalid && req_tready;

   mtcs_csr #(
      .MAX_TONES (MAX_TONES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .phase_step  (phase_step)
   );

   mtcs_tone_acc #(
      .MAX_TONES        (MAX_TONES),
      .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
   ) u_tone_acc (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .restart     (req_tdata[0]),
      .cfg         (cfg),
      .phase_step  (phase_step),
      .phase_top   (phase_top),
      .last_sample (last_sample)
   );

   for (genvar t = 0; t < MAX_TONES; t++) begin : g_cos
      mtcs_cos_lookup #(
         .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
      ) u_cos_lookup (
         .phase_top (phase_top[t]),
         .cos_value (cos_value[t])
      );
   end

   mtcs_mixer #(
      .MAX_TONES (MAX_TONES)
   ) u_mixer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .cos_value  (cos_value),
      .in_last    (last_sample),
      .tone_count (cfg.tone_count),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule
